FILE: rtl/ico_pkg.sv
// ----------------------------------------------------------------------------
// ico_pkg
// shared types, codes and small tables of the icosphere triangle subdivider
// ----------------------------------------------------------------------------
package ico_pkg;

  // nine corner coordinates, entry = corner*3 + axis (a_x is entry 0)
  typedef logic [8:0][15:0] tri_t;

  // job tag: job number within a triangle and zero-sum flag
  typedef struct packed {
    logic [3:0] idx;
    logic       zero;
  } tag_t;

  localparam logic [3:0] LAST_JOB = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SUBDIV = 2'd1;
  localparam logic [1:0] REG_INVERT = 2'd2;

  // vertex ids
  localparam logic [2:0] VID_A   = 3'd0;
  localparam logic [2:0] VID_B   = 3'd1;
  localparam logic [2:0] VID_C   = 3'd2;
  localparam logic [2:0] VID_MAB = 3'd3;
  localparam logic [2:0] VID_MBC = 3'd4;
  localparam logic [2:0] VID_MCA = 3'd5;

  // midpoint served by a job: 0 ab, 1 bc, 2 ca
  function automatic logic [1:0] job_mid(logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // axis served by a job
  function automatic logic [1:0] job_axis(logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // vertex of the subdivided output at triangle t, place p
  function automatic logic [2:0] vsel(logic [1:0] t, logic [1:0] p);
    logic [2:0] r;
    case ({t, p})
      4'b00_00: r = VID_A;
      4'b00_01: r = VID_MAB;
      4'b00_10: r = VID_MCA;
      4'b01_00: r = VID_MAB;
      4'b01_01: r = VID_B;
      4'b01_10: r = VID_MBC;
      4'b10_00: r = VID_MCA;
      4'b10_01: r = VID_MBC;
      4'b10_10: r = VID_C;
      4'b11_00: r = VID_MCA;
      4'b11_01: r = VID_MAB;
      4'b11_10: r = VID_MBC;
      default:  r = VID_A;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ico_front.sv
// ----------------------------------------------------------------------------
// ico_front
// holds a triangle, issues nine component jobs, forms sums and squared length
// ----------------------------------------------------------------------------
module ico_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          in_valid_i,
  input  ico_pkg::tri_t in_tri_i,
  output logic          in_ready_o,
  output logic          job_valid_o,
  output ico_pkg::tag_t job_tag_o,
  output logic          job_neg_o,
  output logic [32:0]   job_sq_o,
  output logic [33:0]   job_len2_o,
  output ico_pkg::tri_t job_tri_o
);
  import ico_pkg::*;

  logic       hold_v_q;
  tri_t       hold_tri_q;
  logic [3:0] cnt_q;
  logic       take;
  logic       done;

  assign done       = adv_i && hold_v_q && (cnt_q == LAST_JOB);
  assign in_ready_o = !hold_v_q || done;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
    end else if (take) begin
      hold_v_q <= 1'b1;
      cnt_q    <= '0;
    end else if (done) begin
      hold_v_q <= 1'b0;
    end else if (adv_i && hold_v_q) begin
      cnt_q <= cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) hold_tri_q <= in_tri_i;
  end

  // stage 1: corner sums of the chosen midpoint
  logic                     s1_v_q;
  logic [3:0]               s1_idx_q;
  logic signed [2:0][16:0]  s1_s_q;
  tri_t                     s1_tri_q;
  logic signed [2:0][16:0]  s_d;
  logic [1:0]               jm, pq;

  always_comb begin
    jm = job_mid(cnt_q);
    pq = (jm == 2'd2) ? 2'd0 : jm + 2'd1;
    for (int a = 0; a < 3; a++) begin
      s_d[a] = 17'(signed'(hold_tri_q[jm * 3 + a])) + 17'(signed'(hold_tri_q[pq * 3 + a]));
    end
  end

  // stage 2: squares and sign of the chosen component
  logic              s2_v_q;
  logic [3:0]        s2_idx_q;
  logic [2:0][32:0]  s2_sq_q;
  logic              s2_neg_q;
  tri_t              s2_tri_q;
  logic [2:0][32:0]  sq_d;
  logic [1:0]        ax1;

  always_comb begin
    logic signed [32:0] sx;
    ax1 = job_axis(s1_idx_q);
    for (int a = 0; a < 3; a++) begin
      // element selects of a packed array are unsigned, so extend the sign here
      sx      = 33'($signed(s1_s_q[a]));
      sq_d[a] = 33'(sx * sx);
    end
  end

  // stage 3: squared length, zero flag and square of the chosen component
  logic        s3_v_q;
  logic [3:0]  s3_idx_q;
  logic        s3_zero_q;
  logic        s3_neg_q;
  logic [32:0] s3_sq_q;
  logic [33:0] s3_len2_q;
  tri_t        s3_tri_q;
  logic [33:0] len2_d;
  logic [1:0]  ax2;

  assign len2_d = 34'(s2_sq_q[0]) + 34'(s2_sq_q[1]) + 34'(s2_sq_q[2]);
  assign ax2    = job_axis(s2_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= hold_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_idx_q  <= cnt_q;
      s1_s_q    <= s_d;
      s1_tri_q  <= hold_tri_q;
      s2_idx_q  <= s1_idx_q;
      s2_sq_q   <= sq_d;
      s2_neg_q  <= s1_s_q[ax1][16];
      s2_tri_q  <= s1_tri_q;
      s3_idx_q  <= s2_idx_q;
      s3_len2_q <= len2_d;
      s3_zero_q <= (len2_d == '0);
      s3_neg_q  <= s2_neg_q;
      s3_sq_q   <= s2_sq_q[ax2];
      s3_tri_q  <= s2_tri_q;
    end
  end

  assign job_valid_o    = s3_v_q;
  assign job_tag_o.idx  = s3_idx_q;
  assign job_tag_o.zero = s3_zero_q;
  assign job_neg_o      = s3_neg_q;
  assign job_sq_o       = s3_sq_q;
  assign job_len2_o     = s3_len2_q;
  assign job_tri_o      = s3_tri_q;

endmodule

FILE: rtl/ico_unit.sv
// ----------------------------------------------------------------------------
// ico_unit
// pipelined unit component: restoring divide, digit square root, rounding
// ----------------------------------------------------------------------------
module ico_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         in_valid_i,
  input  ico_pkg::tag_t                in_tag_i,
  input  logic                         in_neg_i,
  input  logic [32:0]                  in_sq_i,
  input  logic [33:0]                  in_len2_i,
  input  ico_pkg::tri_t                in_tri_i,
  output logic                         out_valid_o,
  output ico_pkg::tag_t                out_tag_o,
  output logic signed [FRAC_BITS+1:0]  out_comp_o,
  output ico_pkg::tri_t                out_tri_o
);
  import ico_pkg::*;

  localparam int DS  = 2 * FRAC_BITS + 3;  // divide stages, one quotient bit each
  localparam int QW  = DS;
  localparam int QP  = QW + 1;             // quotient padded to even width
  localparam int SS  = FRAC_BITS + 2;      // root stages
  localparam int YW  = FRAC_BITS + 2;
  localparam int RW  = FRAC_BITS + 5;
  localparam int MW  = FRAC_BITS + 2;
  localparam int NST = DS + SS + 1;

  logic v_q    [NST];
  tag_t tag_q  [NST];
  logic neg_q  [NST];
  tri_t tri_q  [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) v_q[i] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= in_tag_i;
      neg_q[0] <= in_neg_i;
      tri_q[0] <= in_tri_i;
      for (int i = 1; i < NST; i++) begin
        tag_q[i] <= tag_q[i-1];
        neg_q[i] <= neg_q[i-1];
        tri_q[i] <= tri_q[i-1];
      end
    end
  end

  // divide sq * 2^(2F+2) by len2
  logic [33:0]   div_rem_q [DS];
  logic [QW-1:0] div_quo_q [DS];
  logic [33:0]   div_len_q [DS];

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [34:0]   r2;
    logic [33:0]   len;
    logic          qb;
    logic [33:0]   rem_n;
    logic [QW-1:0] quo_n;
    if (i == 0) begin : g_first
      assign r2    = {2'b00, in_sq_i};
      assign len   = in_len2_i;
      assign quo_n = QW'(qb);
    end else begin : g_next
      assign r2    = {div_rem_q[i-1], 1'b0};
      assign len   = div_len_q[i-1];
      assign quo_n = {div_quo_q[i-1][QW-2:0], qb};
    end
    assign qb    = (r2 >= {1'b0, len});
    assign rem_n = qb ? 34'(r2 - {1'b0, len}) : r2[33:0];
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        div_rem_q[i] <= rem_n;
        div_quo_q[i] <= quo_n;
        div_len_q[i] <= len;
      end
    end
  end

  // integer square root of the quotient, two bits per stage
  logic [QP-1:0] sr_val_q  [SS];
  logic [RW-1:0] sr_rem_q  [SS];
  logic [YW-1:0] sr_root_q [SS];

  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    logic [QP-1:0] val;
    logic [RW-1:0] rem;
    logic [YW-1:0] root;
    logic [RW-1:0] rt, trial, rem_n;
    logic          ge;
    if (j == 0) begin : g_first
      assign val  = {1'b0, div_quo_q[DS-1]};
      assign rem  = '0;
      assign root = '0;
    end else begin : g_next
      assign val  = sr_val_q[j-1];
      assign rem  = sr_rem_q[j-1];
      assign root = sr_root_q[j-1];
    end
    assign rt    = {rem[RW-3:0], val[QP-1-2*j -: 2]};
    assign trial = RW'({root, 2'b01});
    assign ge    = (rt >= trial);
    assign rem_n = ge ? RW'(rt - trial) : rt;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sr_val_q[j]  <= val;
        sr_rem_q[j]  <= rem_n;
        sr_root_q[j] <= {root[YW-2:0], ge};
      end
    end
  end

  // round half up, cap at one, apply sign, force zero on a zero sum
  logic [YW:0]          yp;
  logic [YW-1:0]        m;
  logic [YW-1:0]        mc;
  logic signed [MW-1:0] fin_d, fin_q;
  localparam logic [YW-1:0] ONE = YW'(1) << FRAC_BITS;

  always_comb begin
    yp    = {1'b0, sr_root_q[SS-1]} + (YW+1)'(1);
    m     = yp[YW:1];
    mc    = (m > ONE) ? ONE : m;
    fin_d = tag_q[NST-2].zero ? '0 : (neg_q[NST-2] ? -signed'(mc) : signed'(mc));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) fin_q <= fin_d;
  end

  assign out_valid_o = v_q[NST-1];
  assign out_tag_o   = tag_q[NST-1];
  assign out_comp_o  = fin_q;
  assign out_tri_o   = tri_q[NST-1];

endmodule

FILE: rtl/ico_emit.sv
// ----------------------------------------------------------------------------
// ico_emit
// gathers nine midpoint components, emits vertices one word at a time
// ----------------------------------------------------------------------------
module ico_emit #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  ico_pkg::tag_t               in_tag_i,
  input  logic signed [FRAC_BITS+1:0] in_comp_i,
  input  ico_pkg::tri_t               in_tri_i,
  output logic                        adv_o,
  input  logic [15:0]                 radius_i,
  input  logic                        subdiv_i,
  input  logic                        invert_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [135:0]                out_data_o,
  output logic                        out_last_o
);
  import ico_pkg::*;

  localparam int MW = FRAC_BITS + 2;
  localparam int VW = (MW > 16) ? MW : 16;
  localparam int PW = VW + 17;

  logic signed [MW-1:0] mid_q  [9];
  logic signed [MW-1:0] emid_q [9];
  tri_t                 ecor_q;
  logic                 busy_q;
  logic [1:0]           tri_q, pos_q;
  logic                 ovalid_q, olast_q;
  logic [135:0]         odata_q;

  logic oload, step, fin, can_load, load;

  assign oload    = !ovalid_q || out_ready_i;
  assign step     = busy_q && oload;
  assign fin      = (pos_q == 2'd2) && (tri_q == 2'd3 || !subdiv_i);
  assign can_load = !busy_q || (step && fin);
  assign adv_o    = !(in_valid_i && in_tag_i.idx == LAST_JOB && !can_load);
  assign load     = in_valid_i && in_tag_i.idx == LAST_JOB && can_load;

  always_ff @(posedge clk_i) begin
    if (adv_o && in_valid_i) mid_q[in_tag_i.idx] <= in_comp_i;
    if (load) begin
      ecor_q <= in_tri_i;
      for (int i = 0; i < 8; i++) emid_q[i] <= mid_q[i];
      emid_q[8] <= in_comp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tri_q  <= '0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      tri_q  <= '0;
      pos_q  <= '0;
    end else if (step && fin) begin
      busy_q <= 1'b0;
    end else if (step) begin
      if (pos_q == 2'd2) begin
        pos_q <= '0;
        tri_q <= tri_q + 2'd1;
      end else begin
        pos_q <= pos_q + 2'd1;
      end
    end
  end

  // vertex pick
  logic [1:0]           epos;
  logic [2:0]           vid;
  logic signed [VW-1:0] vx [3];

  always_comb begin
    case (pos_q)
      2'd1:    epos = invert_i ? 2'd2 : 2'd1;
      2'd2:    epos = invert_i ? 2'd1 : 2'd2;
      default: epos = 2'd0;
    endcase
    vid = subdiv_i ? vsel(tri_q, epos) : {1'b0, epos};
    for (int a = 0; a < 3; a++) begin
      case (vid)
        VID_A:   vx[a] = VW'(signed'(ecor_q[a]));
        VID_B:   vx[a] = VW'(signed'(ecor_q[3 + a]));
        VID_C:   vx[a] = VW'(signed'(ecor_q[6 + a]));
        VID_MAB: vx[a] = VW'(emid_q[a]);
        VID_MBC: vx[a] = VW'(emid_q[3 + a]);
        VID_MCA: vx[a] = VW'(emid_q[6 + a]);
        default: vx[a] = '0;
      endcase
    end
  end

  // scale, negate, clamp; texture coordinate from the y component
  localparam logic signed [VW:0]   NMAX = (VW+1)'(32767);
  localparam logic signed [VW:0]   NMIN = -(VW+1)'(32768);
  localparam logic signed [VW+1:0] TMAX = (VW+2)'(32767);
  localparam logic [PW-1:0]        PMAX = PW'(8388607);

  logic [2:0][23:0] pos_d;
  logic [2:0][15:0] nrm_d;
  logic [14:0]      tex_d;

  always_comb begin
    logic              ng;
    logic [VW-1:0]     mag;
    logic [PW-1:0]     pr;
    logic signed [VW:0]   nv;
    logic signed [VW+1:0] tv;
    for (int a = 0; a < 3; a++) begin
      ng  = vx[a][VW-1];
      mag = ng ? VW'(-vx[a]) : VW'(vx[a]);
      pr  = (PW'(mag) * PW'(radius_i) + PW'(128)) >> 8;
      if (!ng) pos_d[a] = (pr > PMAX) ? 24'h7fffff : pr[23:0];
      else     pos_d[a] = (pr > PMAX + PW'(1)) ? 24'h800000 : 24'(-pr);
      nv = invert_i ? -(VW+1)'(vx[a]) : (VW+1)'(vx[a]);
      if (nv > NMAX)      nrm_d[a] = 16'h7fff;
      else if (nv < NMIN) nrm_d[a] = 16'h8000;
      else                nrm_d[a] = nv[15:0];
    end
    tv = ((VW+2)'(vx[1]) + ((VW+2)'(1) <<< FRAC_BITS) + (VW+2)'(1)) >>> 1;
    if (tv < 0)         tex_d = '0;
    else if (tv > TMAX) tex_d = 15'h7fff;
    else                tex_d = tv[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (oload) begin
      ovalid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oload && step) begin
      odata_q <= {1'b0, tex_d, nrm_d[2], nrm_d[1], nrm_d[0], pos_d[2], pos_d[1], pos_d[0]};
      olast_q <= fin;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_last_o  = olast_q;

endmodule

FILE: rtl/icosphere_triangle_subdivider.sv
// ----------------------------------------------------------------------------
// icosphere_triangle_subdivider
// splits a unit-sphere triangle into four (if enabled) with renormalized edge midpoints
// ----------------------------------------------------------------------------
// latency from triangle accept to first vertex spans the nine job issues, the front stages,
//   the 3*FRAC_BITS+6 deep midpoint unit pipe and the emitter; the unit takes one job per
//   cycle unless stalled; a subdivided triangle leaves as twelve vertex words, one per cycle
//   while m_axis_tready is high; pass-through is paced by the nine job issues per triangle
// reset: all pipes empty, radius 1.0, subdivision on, invert off
module icosphere_triangle_subdivider #(
  parameter int FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // config write port
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  // triangle input
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [143:0]   s_axis_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
  // vertex output
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [135:0]   m_axis_tdata,  // pos_x pos_y pos_z norm_x norm_y norm_z tex_v, pad
  output logic           m_axis_tlast   // last_of_item
);
  import ico_pkg::*;

  // config registers
  logic [15:0] radius_q;
  logic        subdiv_q;
  logic        invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      subdiv_q <= 1'b1;
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_wdata_i;
        REG_SUBDIV: subdiv_q <= cfg_wdata_i[0];
        REG_INVERT: invert_q <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // the whole job pipe moves together; it only stops when a finished
  // triangle reaches the emitter while the emitter is still busy
  logic adv;

  logic        j_valid;
  tag_t        j_tag;
  logic        j_neg;
  logic [32:0] j_sq;
  logic [33:0] j_len2;
  tri_t        j_tri;

  ico_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid),
    .in_tri_i    (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .job_valid_o (j_valid),
    .job_tag_o   (j_tag),
    .job_neg_o   (j_neg),
    .job_sq_o    (j_sq),
    .job_len2_o  (j_len2),
    .job_tri_o   (j_tri)
  );

  logic                        u_valid;
  tag_t                        u_tag;
  logic signed [FRAC_BITS+1:0] u_comp;
  tri_t                        u_tri;

  ico_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (j_valid),
    .in_tag_i    (j_tag),
    .in_neg_i    (j_neg),
    .in_sq_i     (j_sq),
    .in_len2_i   (j_len2),
    .in_tri_i    (j_tri),
    .out_valid_o (u_valid),
    .out_tag_o   (u_tag),
    .out_comp_o  (u_comp),
    .out_tri_o   (u_tri)
  );

  ico_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (u_valid),
    .in_tag_i    (u_tag),
    .in_comp_i   (u_comp),
    .in_tri_i    (u_tri),
    .adv_o       (adv),
    .radius_i    (radius_q),
    .subdiv_i    (subdiv_q),
    .invert_i    (invert_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // a triangle holds the issue slot until its nine jobs are issued
  a_issue_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("triangle accepted twice in a row");

  // the pipe only stops on a complete triangle waiting for the emitter
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> u_valid && u_tag.idx == LAST_JOB)
    else $error("pipe stalled without a waiting triangle");

  // zero corner sum gives a zero component
  a_zero_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_valid && u_tag.zero |-> u_comp == '0)
    else $error("zero sum produced nonzero midpoint");

endmodule
